// File: design/length_prefixed_message_fifo_unit_assert.svh
// ----------------------------------------------------------------------------
// length prefixed message fifo unit: assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_UNIT_ASSERT_SVH

// condition that holds at every edge
`define LPMF_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequence in the same cycle
`define LPMF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the following cycle
`define LPMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lpmf_pkg.sv
// ----------------------------------------------------------------------------
// lpmf_pkg
// sizes, codes and state type of the length prefixed message fifo
// ----------------------------------------------------------------------------
package lpmf_pkg;

    localparam int RING_BYTES   = 1024;
    localparam int MAX_MESSAGE  = 64;
    localparam int HEADER_BYTES = 1;

    localparam int CAP_MIN   = 2;
    localparam int CAP_RESET = (1024 < RING_BYTES) ? 1024 : RING_BYTES;

    localparam int PTR_W = $clog2(RING_BYTES);
    localparam int CNT_W = $clog2(RING_BYTES + 1);
    localparam int MSG_W = $clog2(MAX_MESSAGE + 1);
    localparam int HDR_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int EV_W  = (CNT_W > 8) ? CNT_W : 8;

    // port field widths
    localparam int ACTION_W = 2;
    localparam int LEN_W    = 7;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 11;
    localparam int CFG_W    = 11;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OPEN   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_IGNORE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_TOO_LONG   = 3'd3,
        ST_NO_OPEN    = 3'd4,
        ST_WRITE_BUSY = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_HDR,
        S_RD_LEN,
        S_RD_SKIP,
        S_RD_EVAL,
        S_RD_BODY
    } state_t;

endpackage

// File: design/lpmf_ram.sv
// ----------------------------------------------------------------------------
// lpmf_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lpmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/length_prefixed_message_fifo_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_fifo_unit
// byte ring of whole messages, each behind a length header, in one ram
// open and write_byte requests: result in the cycle after acceptance, never busy
// read of n bytes: busy in S_RD_LEN, S_RD_SKIP (headers over one byte), S_RD_EVAL, then
// S_RD_BODY (not for a drop); body bytes come out one per cycle; the receiver cannot stall
// reset and capacity writes empty the ring; no clearing pass is needed
// ----------------------------------------------------------------------------
module length_prefixed_message_fifo_unit
    import lpmf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] action,
    input  logic [LEN_W-1:0]    length,
    input  logic [DATA_W-1:0]   data_in,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   data_out,
    output logic [LEN_W-1:0]    byte_count,
    output logic                last,
    output logic [FREE_W-1:0]   free_space,
    output logic                is_empty
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]  sc_reg, sc_next;
    logic [LEN_W-1:0]  bse_reg, bse_next;
    logic [HDR_W-1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]        msg_reg, msg_next;
    logic [LEN_W-1:0]  limit_reg, limit_next;
    logic [MSG_W-1:0]  left_reg, left_next;

    logic                res_valid_reg, res_valid_next;
    status_t             res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic [LEN_W-1:0]    res_count_reg, res_count_next;
    logic                res_last_reg, res_last_next;
    logic [FREE_W-1:0]   res_free_reg, res_free_next;
    logic                res_empty_reg, res_empty_next;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [7:0]        ram_rdata;

    logic              accept;
    action_t           act;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W:0]    need;
    logic              open_ok;
    logic              read_go;
    logic [EV_W-1:0]   ev_a;
    logic [EV_W-1:0]   ev_b;
    logic [MSG_W-1:0]  ev_msg;
    logic              ev_drop;
    logic [CNT_W:0]    jump_sum;
    logic [PTR_W-1:0]  jump_ptr;
    logic [CNT_W-1:0]  sc_floor_dec;

    // result being formed this cycle
    logic              em_valid;
    status_t           em_status;
    logic [DATA_W-1:0] em_data;
    logic [LEN_W-1:0]  em_count;
    logic              em_last;
    logic [CNT_W-1:0]  em_fin;
    logic [CNT_W-1:0]  em_free;

    logic [CNT_W-1:0]  cfg_cap;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(p) + (CNT_W+1)'(1);
        return (s >= (CNT_W+1)'(cap)) ? '0 : PTR_W'(s);
    endfunction

    lpmf_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign act    = action_t'(action);

    // space check for an open request
    assign avail   = cap_reg - sc_reg;
    assign need    = (CNT_W+1)'(length) + (CNT_W+1)'(HEADER_BYTES);
    assign open_ok = (bse_reg == '0) && (length != '0)
                     && (32'(length) <= MAX_MESSAGE)
                     && ((CNT_W+1)'(avail) >= need);
    assign read_go = (bse_reg == '0) && (sc_reg != '0);

    // stored length clamped to bytes held and to the largest message
    always_comb
    begin
        ev_a = EV_W'(msg_reg);
        ev_b = EV_W'(sc_reg);
        if (ev_b < ev_a)
        begin
            ev_a = ev_b;
        end
        if (ev_a > EV_W'(MAX_MESSAGE))
        begin
            ev_a = EV_W'(MAX_MESSAGE);
        end
    end
    assign ev_msg  = MSG_W'(ev_a);
    assign ev_drop = (limit_reg < LEN_W'(ev_msg));

    // dropped message: read pointer jumps over it, one wrap at most
    assign jump_sum = (CNT_W+1)'(rp_reg) + (CNT_W+1)'(ev_msg);
    assign jump_ptr = (jump_sum >= (CNT_W+1)'(cap_reg))
                      ? PTR_W'(jump_sum - (CNT_W+1)'(cap_reg))
                      : PTR_W'(jump_sum);

    assign sc_floor_dec = (sc_reg != '0) ? sc_reg - CNT_W'(1) : '0;

    always_comb
    begin
        if (32'(cfg_wdata) > RING_BYTES)
        begin
            cfg_cap = CNT_W'(RING_BYTES);
        end
        else if (32'(cfg_wdata) < CAP_MIN)
        begin
            cfg_cap = CNT_W'(CAP_MIN);
        end
        else
        begin
            cfg_cap = CNT_W'(cfg_wdata);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !cfg_we)
                begin
                    if (act == ACT_OPEN && open_ok && HEADER_BYTES > 1)
                    begin
                        state_next = S_WR_HDR;
                    end
                    else if (act == ACT_READ && read_go)
                    begin
                        state_next = S_RD_LEN;
                    end
                end
            end
            S_WR_HDR:
            begin
                if (hdr_cnt_reg == HDR_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_LEN:
            begin
                state_next = (HEADER_BYTES > 1) ? S_RD_SKIP : S_RD_EVAL;
            end
            S_RD_SKIP:
            begin
                if (hdr_cnt_reg == HDR_W'(1))
                begin
                    state_next = S_RD_EVAL;
                end
            end
            S_RD_EVAL:
            begin
                state_next = (!ev_drop && ev_msg != '0) ? S_RD_BODY : S_IDLE;
            end
            S_RD_BODY:
            begin
                if (left_reg == MSG_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, ram requests and result forming
    always_comb
    begin
        cap_next     = cap_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        sc_next      = sc_reg;
        bse_next     = bse_reg;
        hdr_cnt_next = hdr_cnt_reg;
        msg_next     = msg_reg;
        limit_next   = limit_reg;
        left_next    = left_reg;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = rp_reg;

        em_valid  = 1'b0;
        em_status = ST_OK;
        em_data   = '0;
        em_count  = '0;
        em_last   = 1'b1;
        em_fin    = sc_reg;

        if (cfg_we)
        begin
            cap_next = cfg_cap;
            rp_next  = '0;
            wp_next  = '0;
            sc_next  = '0;
            bse_next = '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (act)
                            ACT_OPEN:
                            begin
                                em_valid = 1'b1;
                                if (bse_reg != '0)
                                begin
                                    em_status = ST_WRITE_BUSY;
                                end
                                else if (!open_ok)
                                begin
                                    em_status = ST_NO_SPACE;
                                end
                                else
                                begin
                                    ram_we       = 1'b1;
                                    ram_wdata    = 8'(length);
                                    wp_next      = adv(wp_reg, cap_reg);
                                    sc_next      = sc_reg + CNT_W'(HEADER_BYTES);
                                    bse_next     = length;
                                    hdr_cnt_next = HDR_W'(HEADER_BYTES - 1);
                                    em_count     = length;
                                    em_fin       = sc_reg + CNT_W'(HEADER_BYTES);
                                end
                            end
                            ACT_WRITE:
                            begin
                                em_valid = 1'b1;
                                if (bse_reg == '0)
                                begin
                                    em_status = ST_NO_OPEN;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = data_in;
                                    wp_next   = adv(wp_reg, cap_reg);
                                    sc_next   = sc_reg + CNT_W'(1);
                                    bse_next  = bse_reg - LEN_W'(1);
                                    em_fin    = sc_reg + CNT_W'(1);
                                end
                            end
                            ACT_READ:
                            begin
                                if (bse_reg != '0)
                                begin
                                    em_valid  = 1'b1;
                                    em_status = ST_WRITE_BUSY;
                                end
                                else if (sc_reg == '0)
                                begin
                                    em_valid  = 1'b1;
                                    em_status = ST_EMPTY;
                                end
                                else
                                begin
                                    ram_re       = 1'b1;
                                    rp_next      = adv(rp_reg, cap_reg);
                                    sc_next      = sc_floor_dec;
                                    limit_next   = length;
                                    hdr_cnt_next = HDR_W'(HEADER_BYTES - 1);
                                end
                            end
                            ACT_IGNORE:
                            begin
                                em_valid = 1'b0;
                            end
                            default:
                            begin
                                em_valid = 1'b0;
                            end
                        endcase
                    end
                end
                S_WR_HDR:
                begin
                    // remaining header bytes are zero
                    ram_we       = 1'b1;
                    ram_wdata    = '0;
                    wp_next      = adv(wp_reg, cap_reg);
                    hdr_cnt_next = hdr_cnt_reg - HDR_W'(1);
                end
                S_RD_LEN:
                begin
                    msg_next = ram_rdata;
                end
                S_RD_SKIP:
                begin
                    rp_next      = adv(rp_reg, cap_reg);
                    sc_next      = sc_floor_dec;
                    hdr_cnt_next = hdr_cnt_reg - HDR_W'(1);
                end
                S_RD_EVAL:
                begin
                    msg_next = 8'(ev_msg);
                    sc_next  = sc_reg - CNT_W'(ev_msg);
                    em_fin   = sc_reg - CNT_W'(ev_msg);
                    if (ev_drop)
                    begin
                        rp_next   = jump_ptr;
                        em_valid  = 1'b1;
                        em_status = ST_TOO_LONG;
                    end
                    else if (ev_msg == '0)
                    begin
                        em_valid = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        rp_next   = adv(rp_reg, cap_reg);
                        left_next = ev_msg;
                    end
                end
                S_RD_BODY:
                begin
                    // byte fetched last cycle goes out, next fetch issued unless this byte is the last
                    em_valid  = 1'b1;
                    em_data   = ram_rdata;
                    em_count  = LEN_W'(msg_reg);
                    em_last   = (left_reg == MSG_W'(1));
                    left_next = left_reg - MSG_W'(1);
                    if (left_reg != MSG_W'(1))
                    begin
                        ram_re  = 1'b1;
                        rp_next = adv(rp_reg, cap_reg);
                    end
                end
                default:
                begin
                    em_valid = 1'b0;
                end
            endcase
        end

        em_free = cap_reg - em_fin;
        if (em_free > CNT_W'(HEADER_BYTES))
        begin
            em_free = em_free - CNT_W'(HEADER_BYTES);
        end
        else
        begin
            em_free = '0;
        end

        res_valid_next  = em_valid;
        res_status_next = em_status;
        res_data_next   = em_data;
        res_count_next  = em_count;
        res_last_next   = em_last;
        res_free_next   = FREE_W'(em_free);
        res_empty_next  = (em_fin == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CNT_W'(CAP_RESET);
            rp_reg        <= '0;
            wp_reg        <= '0;
            sc_reg        <= '0;
            bse_reg       <= '0;
            hdr_cnt_reg   <= '0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            sc_reg        <= sc_next;
            bse_reg       <= bse_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg        <= msg_next;
        limit_reg      <= limit_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_count_reg  <= res_count_next;
        res_last_reg   <= res_last_next;
        res_free_reg   <= res_free_next;
        res_empty_reg  <= res_empty_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign data_out     = res_data_reg;
    assign byte_count   = res_count_reg;
    assign last         = res_last_reg;
    assign free_space   = res_free_reg;
    assign is_empty     = res_empty_reg;

`include "length_prefixed_message_fifo_unit_assert.svh"

    `LPMF_ASSERT_ALWAYS(a_count_within_capacity, sc_reg <= cap_reg,
        "stored count exceeds ring capacity")
    `LPMF_ASSERT_ALWAYS(a_pointers_within_capacity,
        (CNT_W'(rp_reg) < cap_reg) && (CNT_W'(wp_reg) < cap_reg),
        "ring pointer beyond capacity")
    `LPMF_ASSERT_NEXT(a_message_stream_unbroken, result_valid && !last,
        result_valid, "gap inside a delivered message")
    `LPMF_ASSERT_IMPLY(a_error_is_single, result_valid && (status != ST_OK),
        last, "error result not marked last")

endmodule
